FILE: src/lph_pkg.sv
// ----------------------------------------------------------------------------
// lph_pkg
// Shared types and constants of the linear probing hash table.
// ----------------------------------------------------------------------------
package lph_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned KEY_BYTES   = 8;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned COUNT_W = 11;

  localparam logic [63:0] DJB2_START = 64'd5381;
  localparam int unsigned DJB2_SHIFT = 5;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_COUNT  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [KEY_W-1:0]   key_bytes;
    logic [3:0]         key_length;
    logic [VALUE_W-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [VALUE_W-1:0] value_out;
    logic [SLOT_W-1:0]  slot_index;
    logic [COUNT_W-1:0] record_count;
  } rsp_t;

endpackage

FILE: src/lph_req_if.sv
// ----------------------------------------------------------------------------
// lph_req_if
// Request channel: valid/ready with the operation payload.
// ----------------------------------------------------------------------------
interface lph_req_if
  import lph_pkg::*;
();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/lph_rsp_if.sv
// ----------------------------------------------------------------------------
// lph_rsp_if
// Result channel: valid/ready with the result payload.
// ----------------------------------------------------------------------------
interface lph_rsp_if
  import lph_pkg::*;
();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/lph_ram.sv
// ----------------------------------------------------------------------------
// lph_ram
// Generic single-port RAM, one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
module lph_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: src/linear_probe_hash_table_core.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open-addressed hash table, djb2 home slot, linear probing over one sweep.
//
//   channel  dir  payload                                   transaction
//   in       in   mode, key_bytes, key_length, value_in     valid & ready
//   out      out  status, value_out, slot_index, record_cnt valid & ready
//   cfg      in   table_size                                cfg_we
//
// One request at a time. Key bytes hash one per cycle (up to KEY_BYTES),
// then S_HASH closes the key, the modulo is a restoring divider, then each
// probed slot passes S_RD and S_CHK through the single-port entry RAM, S_WR
// writes an insert and S_OUT loads the result. A count request goes from
// S_IDLE straight to S_OUT. After reset a clearing pass zeroes all TABLE_DEPTH
// entries of the entry RAM; no request is taken meanwhile. The result register
// frees the core for the next request once the result is taken.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core
  import lph_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  lph_req_if.sink          in_ch,
  lph_rsp_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);
  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned NW    = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned KLW   = $clog2(KEY_BYTES + 1);
  localparam int unsigned ENT_W = 1 + KEY_W + 4 + VALUE_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_DIV, S_RD, S_CHK, S_WR, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic [CFG_W-1:0] cfg_size_r;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [3:0] len_r, len_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic [KLW-1:0] kidx_r, kidx_nxt;
  logic [3:0] lim_r, lim_nxt;
  logic [63:0] hash_r, hash_nxt;
  logic [NW-1:0] slots_r, slots_nxt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic [6:0] dbit_r, dbit_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [NW-1:0] step_r, step_nxt;
  logic out_valid_r, out_valid_nxt;
  rsp_t rsp_r, rsp_nxt;

  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;

  lph_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  logic e_occ;
  logic [KEY_W-1:0] e_key;
  logic [3:0] e_len;
  logic [VALUE_W-1:0] e_val;
  assign {e_occ, e_key, e_len, e_val} = ram_rdata;

  logic [7:0] kbyte;
  logic [NW:0] rem_sh;
  logic [NW-1:0] cfg_slots;
  logic [AW-1:0] idx_inc;

  assign kbyte = key_r[8*kidx_r +: 8];
  assign rem_sh = {rem_r, hash_r[63]};
  assign idx_inc = (({1'b0, idx_r} + 1'b1) >= {1'b0, slots_r}) ? '0 : idx_r + 1'b1;

  always_comb begin
    if (cfg_size_r == '0) begin
      cfg_slots = NW'(1);
    end else if ({21'd0, cfg_size_r} > 32'(TABLE_DEPTH)) begin
      cfg_slots = NW'(TABLE_DEPTH);
    end else begin
      cfg_slots = NW'(cfg_size_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    clr_nxt = clr_r;
    mode_nxt = mode_r;
    key_nxt = key_r;
    len_nxt = len_r;
    val_nxt = val_r;
    kidx_nxt = kidx_r;
    lim_nxt = lim_r;
    hash_nxt = hash_r;
    slots_nxt = slots_r;
    rem_nxt = rem_r;
    dbit_nxt = dbit_r;
    idx_nxt = idx_r;
    step_nxt = step_r;
    out_valid_nxt = out_valid_r;
    rsp_nxt = rsp_r;
    ram_we = 1'b0;
    ram_addr = idx_r;
    ram_wdata = {1'b0, key_r, len_r, val_r};
    in_ch.ready = (state_r == S_IDLE) && !out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_addr = clr_r;
        ram_wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(TABLE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          mode_nxt = in_ch.data.mode;
          key_nxt = in_ch.data.key_bytes;
          val_nxt = in_ch.data.value_in;
          lim_nxt = (in_ch.data.key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES)
                                                           : in_ch.data.key_length;
          len_nxt = '0;
          kidx_nxt = '0;
          hash_nxt = DJB2_START;
          slots_nxt = cfg_slots;
          if (in_ch.data.mode == MODE_COUNT) begin
            rsp_nxt = '{status: ST_OK, value_out: '0, slot_index: '0,
                        record_count: count_r};
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        if ({1'b0, kidx_r} >= {1'b0, KLW'(lim_r)} || kbyte == 8'd0) begin
          // zero remaining key bytes
          for (int i = 0; i < 8; i++) begin
            if (i >= int'(kidx_r)) begin
              key_nxt[8*i +: 8] = 8'd0;
            end
          end
          len_nxt = 4'(kidx_r);
          rem_nxt = '0;
          dbit_nxt = '0;
          state_nxt = S_DIV;
        end else begin
          hash_nxt = (hash_r << DJB2_SHIFT) + hash_r + {56'd0, kbyte};
          kidx_nxt = kidx_r + 1'b1;
        end
      end
      S_DIV: begin
        if ({rem_sh} >= {1'b0, slots_r}) begin
          rem_nxt = NW'(rem_sh - {1'b0, slots_r});
        end else begin
          rem_nxt = NW'(rem_sh);
        end
        hash_nxt = {hash_r[62:0], 1'b0};
        dbit_nxt = dbit_r + 1'b1;
        if (dbit_r == 7'd63) begin
          state_nxt = S_RD;
          step_nxt = '0;
        end
      end
      S_RD: begin
        if (dbit_r == 7'd64) begin
          idx_nxt = AW'(rem_r);
          dbit_nxt = '0;
          ram_addr = AW'(rem_r);
        end
        state_nxt = S_CHK;
      end
      S_CHK: begin
        rsp_nxt = '{status: ST_OK, value_out: '0, slot_index: SLOT_W'(idx_r),
                    record_count: count_r};
        if (!e_occ) begin
          if (mode_r == MODE_INSERT) begin
            state_nxt = S_WR;
            count_nxt = count_r + 1'b1;
            rsp_nxt.record_count = count_r + 1'b1;
          end else begin
            rsp_nxt.status = ST_NOT_FOUND;
            rsp_nxt.slot_index = '0;
            state_nxt = S_OUT;
          end
        end else if (e_key == key_r && e_len == len_r) begin
          case (mode_r)
            MODE_SEARCH: begin
              rsp_nxt.value_out = e_val;
              state_nxt = S_OUT;
            end
            MODE_DELETE: begin
              ram_we = 1'b1;
              ram_wdata = '0;
              if (count_r != '0) begin
                count_nxt = count_r - 1'b1;
              end
              rsp_nxt.record_count = (count_r != '0) ? count_r - 1'b1 : count_r;
              state_nxt = S_OUT;
            end
            default: begin
              state_nxt = S_WR;
            end
          endcase
        end else if (step_r + 1'b1 >= slots_r) begin
          rsp_nxt.status = (mode_r == MODE_INSERT) ? ST_FULL : ST_NOT_FOUND;
          rsp_nxt.slot_index = '0;
          state_nxt = S_OUT;
        end else begin
          step_nxt = step_r + 1'b1;
          idx_nxt = idx_inc;
          state_nxt = S_RD;
        end
      end
      S_WR: begin
        ram_we = 1'b1;
        ram_wdata = {1'b1, key_r, len_r, val_r};
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cfg_size_r <= CFG_W'(TABLE_DEPTH);
      count_r <= '0;
      clr_r <= '0;
      out_valid_r <= 1'b0;
      dbit_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cfg_size_r <= cfg_wdata;
      end
      count_r <= count_nxt;
      clr_r <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      dbit_r <= (state_r == S_DIV && dbit_r == 7'd63) ? 7'd64 : dbit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    key_r <= key_nxt;
    len_r <= len_nxt;
    val_r <= val_nxt;
    kidx_r <= kidx_nxt;
    lim_r <= lim_nxt;
    hash_r <= hash_nxt;
    slots_r <= slots_nxt;
    rem_r <= rem_nxt;
    idx_r <= idx_nxt;
    step_r <= step_nxt;
    rsp_r <= rsp_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data = rsp_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> (state_r == S_IDLE && !out_valid_r))
    else $error("request taken while busy");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, count_r} <= 12'(TABLE_DEPTH))
    else $error("record count above depth");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(rsp_r))
    else $error("result changed while stalled");
endmodule
